// File: rtl/timed_job_slot_table_defines.svh
// Assertion macros for the timed job slot table.
`ifndef TIMED_JOB_SLOT_TABLE_DEFINES_SVH
`define TIMED_JOB_SLOT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define TJST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TJST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TJST_ASSERT(lbl, clk, rst, prop, msg)
`define TJST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/tjst_pkg.sv
// Types and constants shared by the timed job slot table.
package tjst_pkg;

  localparam int SLOTS   = 8;
  localparam int ID_BITS = 8;
  localparam int ID_W    = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TIME_W  = 32;

  localparam logic [TIME_W-1:0] EMPTY_ALARM = 32'hFFFF_FFFF;
  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_EXEC = 2'd2,
    CMD_GET  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_LE,
    CMP_LT
  } cmp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_MIN,
    S_EXEC,
    S_FIRE,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [7:0]        job_id;
    logic [TIME_W-1:0] when;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        fired_id;
    logic [TIME_W-1:0] job_time;
    logic [TIME_W-1:0] alarm;
    status_t           status;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
  } wr_req_t;

  typedef struct packed {
    logic valid;
    rsp_t item;
  } emit_t;

endpackage

// File: rtl/tjst_table.sv
// Slot storage: job ids and due times, one write and one read port.
module tjst_table (
  input  logic                         clk,
  input  tjst_pkg::wr_req_t            wr,
  input  logic [tjst_pkg::IDX_W-1:0]   rd_addr,
  output logic [tjst_pkg::ID_W-1:0]    rd_id,
  output logic [tjst_pkg::TIME_W-1:0]  rd_due
);

  logic [tjst_pkg::ID_W-1:0]   ids  [tjst_pkg::SLOTS];
  logic [tjst_pkg::TIME_W-1:0] dues [tjst_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      ids[wr.addr]  <= wr.id;
      dues[wr.addr] <= wr.due;
    end
  end

  assign rd_id  = ids[rd_addr];
  assign rd_due = dues[rd_addr];

endmodule

// File: rtl/tjst_cmp.sv
// Shared comparator used for id matches, due checks and the minimum scan.
module tjst_cmp (
  input  tjst_pkg::cmp_op_t            op,
  input  logic [tjst_pkg::TIME_W-1:0]  a,
  input  logic [tjst_pkg::TIME_W-1:0]  b,
  output logic                         hit
);

  logic lt;
  logic eq;

  assign lt = a < b;
  assign eq = a == b;

  always_comb begin
    case (op)
      tjst_pkg::CMP_EQ: hit = eq;
      tjst_pkg::CMP_LE: hit = lt | eq;
      tjst_pkg::CMP_LT: hit = lt;
      default:          hit = 1'b0;
    endcase
  end

endmodule

// File: rtl/tjst_ctrl.sv
// Sequencer: walks the slots through the shared comparator for each request.
`include "timed_job_slot_table_defines.svh"
module tjst_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  tjst_pkg::req_t               req,
  input  logic [tjst_pkg::ID_W-1:0]    rd_id,
  input  logic [tjst_pkg::TIME_W-1:0]  rd_due,
  input  logic                         hit,
  input  logic                         room,
  output tjst_pkg::cmp_op_t            cmp_op,
  output logic [tjst_pkg::TIME_W-1:0]  cmp_a,
  output logic [tjst_pkg::TIME_W-1:0]  cmp_b,
  output logic [tjst_pkg::IDX_W-1:0]   rd_addr,
  output tjst_pkg::wr_req_t            wr,
  output tjst_pkg::emit_t              emit,
  output logic                         busy
);

  localparam int IDX_W  = tjst_pkg::IDX_W;
  localparam int CNT_W  = tjst_pkg::CNT_W;
  localparam int ID_W   = tjst_pkg::ID_W;
  localparam int TIME_W = tjst_pkg::TIME_W;

  tjst_pkg::state_t    state, state_next;
  tjst_pkg::cmd_t      cmd, cmd_next;
  tjst_pkg::status_t   status, status_next;
  logic [ID_W-1:0]     id, id_next;
  logic [TIME_W-1:0]   job_when, job_when_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic                found, found_next;
  logic                keep, keep_next;
  logic                sub, sub_next;
  logic [TIME_W-1:0]   alarm, alarm_next;
  logic [TIME_W-1:0]   jt, jt_next;
  logic [ID_W-1:0]     fire_id, fire_id_next;
  logic [TIME_W-1:0]   fire_due, fire_due_next;

  logic [CNT_W-1:0]    tail_c;
  logic [IDX_W-1:0]    tail;
  logic                idx_in;
  logic                has_room;

  assign tail_c   = count - CNT_W'(1);
  assign tail     = tail_c[IDX_W-1:0];
  assign idx_in   = idx < count;
  assign has_room = count < CNT_W'(tjst_pkg::SLOTS);
  assign busy     = state != tjst_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      tjst_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (req.command == tjst_pkg::CMD_EXEC) ? tjst_pkg::S_MIN
                                                           : tjst_pkg::S_FIND;
        end
      end
      tjst_pkg::S_FIND: begin
        if (!idx_in || hit) begin
          state_next = tjst_pkg::S_APPLY;
        end
      end
      tjst_pkg::S_APPLY: state_next = tjst_pkg::S_MIN;
      tjst_pkg::S_MIN: begin
        if (!idx_in) begin
          state_next = (cmd == tjst_pkg::CMD_EXEC) ? tjst_pkg::S_EXEC : tjst_pkg::S_DONE;
        end
      end
      tjst_pkg::S_EXEC: begin
        if (!idx_in) begin
          state_next = tjst_pkg::S_DONE;
        end else if (hit) begin
          state_next = tjst_pkg::S_FIRE;
        end
      end
      tjst_pkg::S_FIRE: begin
        if (room) begin
          state_next = tjst_pkg::S_EXEC;
        end
      end
      tjst_pkg::S_DONE: begin
        if (room) begin
          state_next = tjst_pkg::S_IDLE;
        end
      end
      default: state_next = tjst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_next      = cmd;
    status_next   = status;
    id_next       = id;
    job_when_next = job_when;
    idx_next      = idx;
    count_next    = count;
    pos_next      = pos;
    found_next    = found;
    keep_next     = keep;
    sub_next      = sub;
    alarm_next    = alarm;
    jt_next       = jt;
    fire_id_next  = fire_id;
    fire_due_next = fire_due;
    cmp_op        = tjst_pkg::CMP_LT;
    cmp_a         = rd_due;
    cmp_b         = alarm;
    rd_addr       = idx[IDX_W-1:0];
    wr            = '0;
    emit          = '0;
    case (state)
      tjst_pkg::S_IDLE: begin
        if (accept) begin
          cmd_next      = req.command;
          id_next       = req.job_id[ID_W-1:0];
          job_when_next = req.when;
          idx_next      = '0;
          found_next    = 1'b0;
          sub_next      = 1'b0;
          alarm_next    = tjst_pkg::EMPTY_ALARM;
          status_next   = tjst_pkg::ST_OK;
          jt_next       = '0;
        end
      end
      tjst_pkg::S_FIND: begin
        cmp_op = tjst_pkg::CMP_EQ;
        cmp_a  = TIME_W'(rd_id);
        cmp_b  = TIME_W'(id);
        if (idx_in && hit) begin
          found_next = 1'b1;
          pos_next   = idx[IDX_W-1:0];
        end else if (idx_in) begin
          idx_next = idx + CNT_W'(1);
        end
      end
      tjst_pkg::S_APPLY: begin
        idx_next = '0;
        sub_next = 1'b0;
        case (cmd)
          tjst_pkg::CMD_SET: begin
            if (found) begin
              wr = '{we: 1'b1, addr: pos, id: id, due: job_when};
            end else if (has_room) begin
              wr         = '{we: 1'b1, addr: count[IDX_W-1:0], id: id, due: job_when};
              count_next = count + CNT_W'(1);
            end else begin
              status_next = tjst_pkg::ST_FULL;
            end
          end
          tjst_pkg::CMD_DEL: begin
            rd_addr = tail;
            if (found) begin
              wr         = '{we: 1'b1, addr: pos, id: rd_id, due: rd_due};
              count_next = tail_c;
            end else begin
              status_next = tjst_pkg::ST_NOT_FOUND;
            end
          end
          tjst_pkg::CMD_GET: begin
            rd_addr = pos;
            if (found) begin
              jt_next = rd_due;
            end else begin
              status_next = tjst_pkg::ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
      tjst_pkg::S_MIN: begin
        // execute: alarm covers only the slots that will survive
        if (cmd == tjst_pkg::CMD_EXEC && !sub) begin
          cmp_op = tjst_pkg::CMP_LE;
          cmp_b  = job_when;
          if (idx_in) begin
            keep_next = !hit;
            sub_next  = 1'b1;
          end
        end else if (idx_in) begin
          if (hit && (cmd != tjst_pkg::CMD_EXEC || keep)) begin
            alarm_next = rd_due;
          end
          idx_next = idx + CNT_W'(1);
          sub_next = 1'b0;
        end
        if (!idx_in) begin
          idx_next = '0;
        end
      end
      tjst_pkg::S_EXEC: begin
        cmp_op = tjst_pkg::CMP_LE;
        cmp_b  = job_when;
        if (idx_in && hit) begin
          fire_id_next  = rd_id;
          fire_due_next = rd_due;
        end else if (idx_in) begin
          idx_next = idx + CNT_W'(1);
        end
      end
      tjst_pkg::S_FIRE: begin
        rd_addr = tail;
        if (room) begin
          emit.valid         = 1'b1;
          emit.item.kind     = tjst_pkg::KIND_FIRED;
          emit.item.fired_id = 8'(fire_id);
          emit.item.job_time = fire_due;
          emit.item.alarm    = alarm;
          emit.item.status   = tjst_pkg::ST_OK;
          emit.item.last     = 1'b0;
          // tail moves into the freed slot, which is then checked again
          wr         = '{we: 1'b1, addr: idx[IDX_W-1:0], id: rd_id, due: rd_due};
          count_next = tail_c;
        end
      end
      tjst_pkg::S_DONE: begin
        if (room) begin
          emit.valid         = 1'b1;
          emit.item.kind     = tjst_pkg::KIND_DONE;
          emit.item.fired_id = (cmd == tjst_pkg::CMD_EXEC) ? 8'd0 : 8'(id);
          emit.item.job_time = jt;
          emit.item.alarm    = alarm;
          emit.item.status   = status;
          emit.item.last     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tjst_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cmd      <= cmd_next;
    status   <= status_next;
    id       <= id_next;
    job_when <= job_when_next;
    idx      <= idx_next;
    pos      <= pos_next;
    found    <= found_next;
    keep     <= keep_next;
    sub      <= sub_next;
    alarm    <= alarm_next;
    jt       <= jt_next;
    fire_id  <= fire_id_next;
    fire_due <= fire_due_next;
  end

  `TJST_ASSERT(a_count_max, clk, rst, count <= CNT_W'(tjst_pkg::SLOTS), "slot count over capacity")
  `TJST_ASSERT(a_emit_state, clk, rst, emit.valid |-> (state == tjst_pkg::S_FIRE || state == tjst_pkg::S_DONE), "result outside report states")
  `TJST_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "request accepted without starting")
  `TJST_ASSERT_NEXT(a_fire_shrinks, clk, rst, emit.valid && !emit.item.last, count == $past(tail_c), "fired job not removed")

endmodule

// File: rtl/timed_job_slot_table.sv
// Timed job slot table top level: sequencer, shared comparator, slots, result register.
// Set, delete and get search the slots for the id, apply the command, then rescan for the alarm.
// Execute finds the alarm over the surviving slots, then removes and reports each due job.
// A new request is taken only when idle, so not until the completion result is registered.
// A finished result sits in the output register while the next request is taken.
// Reset empties the table (count to zero); slot contents are not cleared.
module timed_job_slot_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tjst_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tjst_pkg::rsp_t  rsp
);

  logic                          accept;
  logic                          busy;
  logic                          room;
  logic                          hit;
  tjst_pkg::cmp_op_t             cmp_op;
  logic [tjst_pkg::TIME_W-1:0]   cmp_a;
  logic [tjst_pkg::TIME_W-1:0]   cmp_b;
  logic [tjst_pkg::IDX_W-1:0]    rd_addr;
  logic [tjst_pkg::ID_W-1:0]     rd_id;
  logic [tjst_pkg::TIME_W-1:0]   rd_due;
  tjst_pkg::wr_req_t             wr;
  tjst_pkg::emit_t               emit;

  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign room      = !rsp_valid || !rsp_stall;

  tjst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .rd_id   (rd_id),
    .rd_due  (rd_due),
    .hit     (hit),
    .room    (room),
    .cmp_op  (cmp_op),
    .cmp_a   (cmp_a),
    .cmp_b   (cmp_b),
    .rd_addr (rd_addr),
    .wr      (wr),
    .emit    (emit),
    .busy    (busy)
  );

  tjst_cmp u_cmp (
    .op  (cmp_op),
    .a   (cmp_a),
    .b   (cmp_b),
    .hit (hit)
  );

  tjst_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_due  (rd_due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (room) begin
      rsp_valid <= emit.valid;
    end
    if (emit.valid) begin
      rsp <= emit.item;
    end
  end

endmodule
